>>> rtl/eav_pkg.sv
// package for the email address stream validator
// item types, character constants and length limits; no dependencies
package eav_pkg;

    // longest raw address taken before it is flagged
    localparam int MAX_RAW_LENGTH = 1024;
    localparam int POS_W          = $clog2(MAX_RAW_LENGTH + 1);

    localparam logic [15:0] CH_AT     = 16'h0040;
    localparam logic [15:0] CH_DOT    = 16'h002e;
    localparam logic [15:0] CH_HYPHEN = 16'h002d;
    localparam logic [15:0] ASCII_MAX = 16'h007f;

    localparam logic [6:0] LOCAL_MAX = 7'd64;
    localparam logic [6:0] LABEL_MAX = 7'd63;
    localparam logic [8:0] EMAIL_MAX = 9'd254;

    typedef struct packed {
        logic [15:0] char_code;
        logic        last;
    } t_in_item;

    typedef struct packed {
        logic [15:0] lower_char;
        logic        done_res;
        logic        valid_res;
        logic [9:0]  start_offset;
        logic [7:0]  email_length;
    } t_out_item;

    // classification of one code unit
    typedef struct packed {
        logic        is_space;
        logic        is_ascii;
        logic        is_alnum;
        logic        is_local_sym;
        logic        is_at;
        logic        is_dot;
        logic        is_hyphen;
        logic [15:0] lower;
    } t_char_class;

endpackage

>>> rtl/eav_char_class.sv
// character classifier for the email address stream validator
// depends on eav_pkg
module eav_char_class (
    input  logic [15:0]         i_code,
    output eav_pkg::t_char_class o_cls
);
    import eav_pkg::*;

    logic is_upper;
    logic is_lower;
    logic is_digit;

    always_comb begin
        is_upper = (i_code >= 16'h0041) && (i_code <= 16'h005a);
        is_lower = (i_code >= 16'h0061) && (i_code <= 16'h007a);
        is_digit = (i_code >= 16'h0030) && (i_code <= 16'h0039);

        o_cls.is_space  = (i_code == 16'h0020) ||
                          ((i_code >= 16'h0009) && (i_code <= 16'h000d));
        o_cls.is_ascii  = (i_code <= ASCII_MAX);
        o_cls.is_alnum  = is_upper || is_lower || is_digit;
        o_cls.is_at     = (i_code == CH_AT);
        o_cls.is_dot    = (i_code == CH_DOT);
        o_cls.is_hyphen = (i_code == CH_HYPHEN);
        // !#$%&'*+/=?^_`{|}~.-
        o_cls.is_local_sym = i_code inside {16'h0021, [16'h0023:16'h0027],
                                            16'h002a, 16'h002b,
                                            [16'h002d:16'h002f], 16'h003d,
                                            16'h003f, [16'h005e:16'h0060],
                                            [16'h007b:16'h007e]};
        o_cls.lower = is_upper ? (i_code + 16'h0020) : i_code;
    end

endmodule

>>> rtl/email_address_stream_validator_top.sv
// email address stream validator, top level
// an accepted item waits in the input register, and its result then waits in the result register
// throughput: one item per cycle while the result side takes results, as the scan state updates once per item
// the result register lets a new item enter while an earlier result waits
// reset: i_rst_n synchronous active low, clears handshake valids and all scan state
// depends on eav_pkg and eav_char_class
module email_address_stream_validator_top (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  eav_pkg::t_in_item  i_in_item,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output eav_pkg::t_out_item o_out_item
);
    import eav_pkg::*;

    // scan phase of the current address
    typedef enum logic [1:0] {
        PH_LEAD   = 2'd0,
        PH_LOCAL  = 2'd1,
        PH_DOMAIN = 2'd2
    } t_phase;

    // class of the previous content character
    typedef enum logic [1:0] {
        PC_NONE   = 2'd0,
        PC_OTHER  = 2'd1,
        PC_DOT    = 2'd2,
        PC_HYPHEN = 2'd3
    } t_prev;

    // input register
    logic        r_in_vld;
    t_in_item    r_in;

    // result register
    logic        r_out_vld;
    t_out_item   r_out;

    // per-address scan state
    logic [POS_W-1:0] r_pos,        n_pos;
    t_phase           r_phase,      n_phase;
    logic [9:0]       r_lead,       n_lead;
    logic [8:0]       r_clen,       n_clen;
    logic             r_gap,        n_gap;      // whitespace seen after content began
    logic [6:0]       r_loclen,     n_loclen;
    logic [6:0]       r_lablen,     n_lablen;
    logic             r_label_seen, n_label_seen; // a domain label has been closed
    t_prev            r_prev,       n_prev;
    logic             r_err,        n_err;

    t_char_class cls;
    t_out_item   res;
    logic        adv;
    logic        ok;

    eav_char_class u_class (
        .i_code (r_in.char_code),
        .o_cls  (cls)
    );

    // the held item moves on when the result register is free or draining
    assign adv        = r_in_vld && (!r_out_vld || i_out_ready);
    assign o_in_ready = !r_in_vld || adv;
    assign o_out_valid = r_out_vld;
    assign o_out_item  = r_out;

    // next scan state for the item in the input register
    always_comb begin
        n_pos        = r_pos;
        n_phase      = r_phase;
        n_lead       = r_lead;
        n_clen       = r_clen;
        n_gap        = r_gap;
        n_loclen     = r_loclen;
        n_lablen     = r_lablen;
        n_label_seen = r_label_seen;
        n_prev       = r_prev;
        n_err        = r_err;

        // raw length limit
        if (r_pos >= POS_W'(MAX_RAW_LENGTH)) begin
            n_err = 1'b1;
        end else begin
            n_pos = r_pos + POS_W'(1);
        end

        if (cls.is_space) begin
            // leading whitespace counts toward the offset, later whitespace is a gap
            if (r_phase == PH_LOCAL || r_phase == PH_DOMAIN) begin
                if (r_gap == 1'b0) begin
                    n_gap = 1'b1;
                end
            end else begin
                if (r_lead != 10'h3ff) begin
                    n_lead = r_lead + 10'd1;
                end
            end
        end else begin
            // content character: anything after an inner gap rejects
            if (r_gap && (r_phase == PH_LOCAL || r_phase == PH_DOMAIN)) begin
                n_err = 1'b1;
            end
            if (!cls.is_ascii) begin
                n_err = 1'b1;
            end
            if (r_clen != 9'h1ff) begin
                n_clen = r_clen + 9'd1;
            end

            if (r_phase == PH_DOMAIN) begin
                // domain labels
                if (cls.is_dot) begin
                    if (r_lablen == 7'd0 || r_prev == PC_HYPHEN) begin
                        n_err = 1'b1;
                    end
                    n_label_seen = 1'b1;
                    n_lablen     = 7'd0;
                    n_prev       = PC_DOT;
                end else if (cls.is_alnum || cls.is_hyphen) begin
                    if (cls.is_hyphen && r_lablen == 7'd0) begin
                        n_err = 1'b1;
                    end
                    if (r_lablen != 7'h7f) begin
                        n_lablen = r_lablen + 7'd1;
                    end
                    if (n_lablen > LABEL_MAX) begin
                        n_err = 1'b1;
                    end
                    n_prev = cls.is_hyphen ? PC_HYPHEN : PC_OTHER;
                end else begin
                    n_err  = 1'b1;
                    n_prev = PC_OTHER;
                end
            end else begin
                // local part; the first content character also lands here
                n_phase = PH_LOCAL;
                if (cls.is_at) begin
                    if (r_loclen == 7'd0 || r_prev == PC_DOT) begin
                        n_err = 1'b1;
                    end
                    n_phase      = PH_DOMAIN;
                    n_lablen     = 7'd0;
                    n_label_seen = 1'b0;
                    n_prev       = PC_NONE;
                end else begin
                    if (!cls.is_alnum && !cls.is_local_sym) begin
                        n_err = 1'b1;
                    end
                    if (cls.is_dot) begin
                        if (r_loclen == 7'd0 || r_prev == PC_DOT) begin
                            n_err = 1'b1;
                        end
                        n_prev = PC_DOT;
                    end else begin
                        n_prev = PC_OTHER;
                    end
                    if (r_loclen != 7'h7f) begin
                        n_loclen = r_loclen + 7'd1;
                    end
                    if (n_loclen > LOCAL_MAX) begin
                        n_err = 1'b1;
                    end
                end
            end
        end

        // verdict on the final state of the address
        ok = !n_err && (n_phase == PH_DOMAIN) && (n_clen != 9'd0) &&
             (n_clen <= EMAIL_MAX) && (n_lablen != 7'd0) &&
             (n_prev != PC_HYPHEN) && n_label_seen;

        res.lower_char   = cls.lower;
        res.done_res     = r_in.last;
        res.valid_res    = r_in.last && ok;
        res.start_offset = r_in.last ? n_lead : 10'd0;
        res.email_length = (r_in.last && ok) ? n_clen[7:0] : 8'd0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld     <= 1'b0;
            r_out_vld    <= 1'b0;
            r_pos        <= '0;
            r_phase      <= PH_LEAD;
            r_lead       <= '0;
            r_clen       <= '0;
            r_gap        <= 1'b0;
            r_loclen     <= '0;
            r_lablen     <= '0;
            r_label_seen <= 1'b0;
            r_prev       <= PC_NONE;
            r_err        <= 1'b0;
        end else begin
            // input register
            if (i_in_valid && o_in_ready) begin
                r_in_vld <= 1'b1;
                r_in     <= i_in_item;
            end else if (adv) begin
                r_in_vld <= 1'b0;
            end

            // result register
            if (adv) begin
                r_out_vld <= 1'b1;
                r_out     <= res;
            end else if (i_out_ready) begin
                r_out_vld <= 1'b0;
            end

            // scan state, cleared after the last item of an address
            if (adv) begin
                if (r_in.last) begin
                    r_pos        <= '0;
                    r_phase      <= PH_LEAD;
                    r_lead       <= '0;
                    r_clen       <= '0;
                    r_gap        <= 1'b0;
                    r_loclen     <= '0;
                    r_lablen     <= '0;
                    r_label_seen <= 1'b0;
                    r_prev       <= PC_NONE;
                    r_err        <= 1'b0;
                end else begin
                    r_pos        <= n_pos;
                    r_phase      <= n_phase;
                    r_lead       <= n_lead;
                    r_clen       <= n_clen;
                    r_gap        <= n_gap;
                    r_loclen     <= n_loclen;
                    r_lablen     <= n_lablen;
                    r_label_seen <= n_label_seen;
                    r_prev       <= n_prev;
                    r_err        <= n_err;
                end
            end
        end
    end

`ifndef SYNTHESIS
    // a held item is not dropped while the result side stalls
    a_hold_in: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_vld && !adv |=> r_in_vld)
        else $error("input item lost during stall");

    // the last item of an address clears the scan state
    a_clear_on_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        adv && r_in.last |=> (r_phase == PH_LEAD) && (r_clen == 9'd0) && !r_err)
        else $error("scan state not cleared after last item");

    // an accepted address has a trimmed length in range
    a_valid_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_item.valid_res |->
            o_out_item.done_res && (o_out_item.email_length != 8'd0) &&
            (o_out_item.email_length != 8'hff))
        else $error("valid verdict with bad length");

    // verdict fields stay zero before the last item
    a_not_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_item.done_res |->
            !o_out_item.valid_res && (o_out_item.start_offset == 10'd0) &&
            (o_out_item.email_length == 8'd0))
        else $error("verdict fields set on a non-final item");

    // reaching the domain with an empty local part must have flagged an error
    a_empty_local: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_DOMAIN) && (r_loclen == 7'd0) |-> r_err)
        else $error("empty local part not flagged");
`endif

endmodule

>>> tb/sv/testbench.sv
`timescale 1ns / 1ps
// testbench for email_address_stream_validator_top: streams addresses one code unit per item
// and checks every result against an address scan predictor kept in step with the block, or a hand-typed result
// depends on eav_pkg and the rtl top level
module testbench;
    import eav_pkg::*;

    // scan phase and class of the previous content unit, as the predictor tracks them
    typedef enum logic [1:0] {PH_LEAD, PH_LOCAL, PH_DOMAIN, PH_SPARE} t_phase;
    typedef enum logic [1:0] {CL_NONE, CL_OTHER, CL_DOT, CL_HYPHEN} t_class;

    localparam logic [15:0] CH_SPACE = 16'h0020;
    localparam logic [15:0] CH_TAB   = 16'h0009;
    localparam logic [15:0] CH_CR    = 16'h000d;

    // run limit in ns, far beyond the slowest correct run
    localparam int RUN_LIMIT_NS   = 2_000_000;
    localparam int RANDOM_ITEMS   = 400;
    localparam int HOLD_OFF_CYCLES = 400;

    // one row of the directed table; has_exp marks a result typed in by hand
    typedef struct packed {
        logic [15:0] char_code;
        logic        last;
        logic        has_exp;
        t_out_item   exp;
    } t_row;

    localparam int DIRECTED_ROWS = 25;

    // directed addresses, one code unit per row:
    //   single units: all ones, all zeros, a bare letter, a lone blank
    //   " A@B.C<tab>" valid with trimming on both ends
    //   "a b@c.d" blank inside the content
    //   "Z@-y.z" domain label starting with a hyphen
    //   "." a lone dot
    t_row directed_table [DIRECTED_ROWS] = '{
        '{16'hffff, 1'b1, 1'b1, '{16'hffff, 1'b1, 1'b0, 10'd0, 8'd0}},
        '{16'h0000, 1'b1, 1'b1, '{16'h0000, 1'b1, 1'b0, 10'd0, 8'd0}},
        '{16'h0041, 1'b1, 1'b1, '{16'h0061, 1'b1, 1'b0, 10'd0, 8'd0}},
        '{16'h0020, 1'b1, 1'b1, '{16'h0020, 1'b1, 1'b0, 10'd1, 8'd0}},
        '{16'h0020, 1'b0, 1'b1, '{16'h0020, 1'b0, 1'b0, 10'd0, 8'd0}},
        '{16'h0041, 1'b0, 1'b1, '{16'h0061, 1'b0, 1'b0, 10'd0, 8'd0}},
        '{16'h0040, 1'b0, 1'b0, '0},
        '{16'h0042, 1'b0, 1'b0, '0},
        '{16'h002e, 1'b0, 1'b0, '0},
        '{16'h0043, 1'b0, 1'b0, '0},
        '{16'h0009, 1'b1, 1'b1, '{16'h0009, 1'b1, 1'b1, 10'd1, 8'd5}},
        '{16'h0061, 1'b0, 1'b0, '0},
        '{16'h0020, 1'b0, 1'b0, '0},
        '{16'h0062, 1'b0, 1'b0, '0},
        '{16'h0040, 1'b0, 1'b0, '0},
        '{16'h0063, 1'b0, 1'b0, '0},
        '{16'h002e, 1'b0, 1'b0, '0},
        '{16'h0064, 1'b1, 1'b1, '{16'h0064, 1'b1, 1'b0, 10'd0, 8'd0}},
        '{16'h005a, 1'b0, 1'b0, '0},
        '{16'h0040, 1'b0, 1'b0, '0},
        '{16'h002d, 1'b0, 1'b0, '0},
        '{16'h0079, 1'b0, 1'b0, '0},
        '{16'h002e, 1'b0, 1'b0, '0},
        '{16'h007a, 1'b1, 1'b1, '{16'h007a, 1'b1, 1'b0, 10'd0, 8'd0}},
        '{16'h002e, 1'b1, 1'b1, '{16'h002e, 1'b1, 1'b0, 10'd0, 8'd0}}
    };

    logic      clk       = 1'b0;
    logic      rst_n     = 1'b0;
    logic      in_valid  = 1'b0;
    t_in_item  in_item   = '0;
    logic      out_ready = 1'b0;
    logic      in_ready;
    logic      out_valid;
    t_out_item out_item;

    // results still owed by the block, oldest first
    t_out_item   pending_results [$];
    // code units of the address being built
    logic [15:0] addr_units [$];
    int          fail_count = 0;
    int          burst_left = 0;
    // raised by the sender, cleared by the receiver once its hold-off is over
    bit          hold_req = 1'b0;

    // predictor copy of the scan state
    logic [POS_W-1:0] sc_position;
    t_phase           sc_phase;
    logic [9:0]       sc_lead;
    logic [8:0]       sc_content;
    logic [9:0]       sc_blanks;
    logic [6:0]       sc_local;
    logic [6:0]       sc_label;
    logic [7:0]       sc_labels;
    t_class           sc_prev;
    logic             sc_error;

    email_address_stream_validator_top uut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_item   (in_item),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_item  (out_item)
    );

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // ---------------------------------------------------------------- predictor

    function automatic void scan_clear();
        sc_position = '0;
        sc_phase    = PH_LEAD;
        sc_lead     = '0;
        sc_content  = '0;
        sc_blanks   = '0;
        sc_local    = '0;
        sc_label    = '0;
        sc_labels   = '0;
        sc_prev     = CL_NONE;
        sc_error    = 1'b0;
    endfunction

    // ascii whitespace: space and tab through carriage return
    function automatic bit is_blank(logic [15:0] c);
        return c == CH_SPACE || (c >= CH_TAB && c <= CH_CR);
    endfunction

    function automatic bit is_alnum(logic [15:0] c);
        return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || (c >= "0" && c <= "9");
    endfunction

    // symbols allowed in the local part besides alphanumerics
    function automatic bit is_local_sym(logic [15:0] c);
        case (c)
            "!", "#", "$", "%", "&", "'", "*", "+", "/", "=", "?", "^", "_",
            16'h0060, "{", "|", "}", "~", ".", "-": return 1'b1;
            default: return 1'b0;
        endcase
    endfunction

    // one content unit of the local part, the @ included
    function automatic void scan_local(logic [15:0] c);
        if (c == CH_AT) begin
            if (sc_local == 0 || sc_prev == CL_DOT) sc_error = 1'b1;
            sc_phase  = PH_DOMAIN;
            sc_label  = '0;
            sc_labels = '0;
            sc_prev   = CL_NONE;
        end else begin
            if (!is_alnum(c) && !is_local_sym(c)) sc_error = 1'b1;
            if (c == CH_DOT) begin
                // no leading or doubled dot
                if (sc_local == 0 || sc_prev == CL_DOT) sc_error = 1'b1;
                sc_prev = CL_DOT;
            end else begin
                sc_prev = CL_OTHER;
            end
            if (sc_local != 7'h7f) sc_local++;
            if (sc_local > LOCAL_MAX) sc_error = 1'b1;
        end
    endfunction

    // advances the predictor by one item and returns the result it owes
    function automatic t_out_item scan_char(t_in_item it);
        t_out_item   r;
        logic [15:0] c;
        bit          ok;
        c = it.char_code;
        r = '0;
        r.lower_char = (c >= "A" && c <= "Z") ? c + 16'h0020 : c;

        // over-long raw input
        if (sc_position >= MAX_RAW_LENGTH) sc_error = 1'b1;
        else sc_position++;

        if (sc_phase == PH_LOCAL || sc_phase == PH_DOMAIN) begin
            if (is_blank(c)) begin
                if (sc_blanks != 10'h3ff) sc_blanks++;
            end else begin
                // any blank before this unit sits inside the content
                if (sc_blanks != 0) sc_error = 1'b1;
                if (c > ASCII_MAX) sc_error = 1'b1;
                if (sc_content != 9'h1ff) sc_content++;
                if (sc_phase == PH_LOCAL) begin
                    scan_local(c);
                end else if (c == CH_DOT) begin
                    if (sc_label == 0 || sc_prev == CL_HYPHEN) sc_error = 1'b1;
                    if (sc_labels != 8'hff) sc_labels++;
                    sc_label = '0;
                    sc_prev  = CL_DOT;
                end else if (is_alnum(c) || c == CH_HYPHEN) begin
                    if (c == CH_HYPHEN && sc_label == 0) sc_error = 1'b1;
                    if (sc_label != 7'h7f) sc_label++;
                    if (sc_label > LABEL_MAX) sc_error = 1'b1;
                    sc_prev = (c == CH_HYPHEN) ? CL_HYPHEN : CL_OTHER;
                end else begin
                    sc_error = 1'b1;
                    sc_prev  = CL_OTHER;
                end
            end
        end else begin
            // leading phase; the spare phase value behaves the same way
            if (is_blank(c)) begin
                if (sc_lead != 10'h3ff) sc_lead++;
            end else begin
                sc_phase = PH_LOCAL;
                if (c > ASCII_MAX) sc_error = 1'b1;
                if (sc_content != 9'h1ff) sc_content++;
                scan_local(c);
            end
        end

        if (it.last) begin
            ok = !sc_error && sc_phase == PH_DOMAIN && sc_content != 0 &&
                 sc_content <= EMAIL_MAX && sc_label != 0 && sc_prev != CL_HYPHEN &&
                 sc_labels != 0;
            r.done_res     = 1'b1;
            r.valid_res    = ok;
            r.start_offset = sc_lead;
            r.email_length = ok ? sc_content[7:0] : 8'd0;
            scan_clear();
        end
        return r;
    endfunction

    // ---------------------------------------------------------------- address generator

    function automatic logic [15:0] rand_alnum();
        case ($urandom_range(2))
            0:       return 16'h0061 + 16'($urandom_range(25));
            1:       return 16'h0041 + 16'($urandom_range(25));
            default: return 16'h0030 + 16'($urandom_range(9));
        endcase
    endfunction

    function automatic logic [15:0] rand_blank();
        return ($urandom_range(4) == 0) ? CH_SPACE : CH_TAB + 16'($urandom_range(4));
    endfunction

    function automatic logic [15:0] rand_local_sym();
        logic [15:0] c;
        do c = 16'($urandom_range(16'h0021, 16'h007e)); while (!is_local_sym(c));
        return c;
    endfunction

    // one domain label of alphanumerics with hyphens inside
    function automatic void add_label(int len);
        for (int i = 0; i < len; i++) begin
            if (i > 0 && i < len - 1 && $urandom_range(6) == 0) addr_units.push_back(CH_HYPHEN);
            else addr_units.push_back(rand_alnum());
        end
    endfunction

    // fills addr_units with one address: mostly well formed, some broken, some noise
    function automatic void build_address();
        int kind, len, labels, pos;
        addr_units.delete();
        kind = $urandom_range(99);
        if (kind < 8) begin
            // noise of any code units
            len = $urandom_range(1, 8);
            for (int i = 0; i < len; i++) begin
                case ($urandom_range(3))
                    0:       addr_units.push_back(16'($urandom));
                    1:       addr_units.push_back(16'($urandom_range(16'h0020, 16'h007e)));
                    2:       addr_units.push_back($urandom_range(1) ? CH_AT : CH_DOT);
                    default: addr_units.push_back(rand_blank());
                endcase
            end
            return;
        end
        if (kind < 12) begin
            // around the length limits: local part 64, labels 63, total 253 to 255
            for (int i = 0; i < 64; i++) addr_units.push_back(rand_alnum());
            addr_units.push_back(CH_AT);
            add_label(63);
            addr_units.push_back(CH_DOT);
            add_label(63);
            addr_units.push_back(CH_DOT);
            add_label($urandom_range(60, 62));
            return;
        end

        if ($urandom_range(3) == 0)
            repeat ($urandom_range(1, 3)) addr_units.push_back(rand_blank());

        len = ($urandom_range(15) == 0) ? $urandom_range(60, 66) : $urandom_range(1, 10);
        for (int i = 0; i < len; i++) begin
            case ($urandom_range(9))
                0: addr_units.push_back(rand_local_sym());
                1: begin
                    if (i > 0 && i < len - 1 && addr_units[$] != CH_DOT)
                        addr_units.push_back(CH_DOT);
                    else
                        addr_units.push_back(rand_alnum());
                end
                default: addr_units.push_back(rand_alnum());
            endcase
        end
        addr_units.push_back(CH_AT);

        labels = ($urandom_range(7) == 0) ? 1 : $urandom_range(2, 4);
        for (int l = 0; l < labels; l++) begin
            if (l > 0) addr_units.push_back(CH_DOT);
            add_label(($urandom_range(19) == 0) ? $urandom_range(60, 64) : $urandom_range(1, 8));
        end

        if ($urandom_range(3) == 0)
            repeat ($urandom_range(1, 2)) addr_units.push_back(rand_blank());

        // break about a quarter of them
        if ($urandom_range(3) == 0) begin
            pos = $urandom_range(addr_units.size() - 1);
            case ($urandom_range(5))
                0: addr_units[pos] = 16'($urandom);
                1: addr_units.insert(pos, rand_blank());
                2: addr_units.insert(pos, CH_AT);
                3: addr_units.insert(pos, CH_DOT);
                4: addr_units[pos] = CH_HYPHEN;
                default: if (addr_units.size() > 1) addr_units.delete(pos);
            endcase
        end
    endfunction

    // ---------------------------------------------------------------- sender

    // offers one item in bursts with random gaps, then books its result once accepted
    task automatic send_item(t_in_item it, bit has_exp, t_out_item typed_exp);
        t_out_item r;
        if (burst_left == 0) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clk);
            // long bursts leave stretches with no sender idling at all
            burst_left = ($urandom_range(3) == 0) ? $urandom_range(50, 200)
                                                  : $urandom_range(1, 12);
        end
        burst_left--;
        in_valid <= 1'b1;
        in_item  <= it;
        do @(posedge clk); while (!in_ready);
        // predictor always advances; a hand-typed result takes its place where given
        r = scan_char(it);
        pending_results.push_back(has_exp ? typed_exp : r);
    endtask

    // streams addr_units as one address
    task automatic send_address();
        t_in_item it;
        foreach (addr_units[k]) begin
            it.char_code = addr_units[k];
            it.last      = (k == addr_units.size() - 1);
            send_item(it, 1'b0, '0);
        end
    endtask

    initial begin : stimulus
        t_in_item it;
        int       random_items;
        bit       hold_done;
        random_items = 0;
        hold_done    = 1'b0;
        scan_clear();

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // directed table
        foreach (directed_table[i]) begin
            it.char_code = directed_table[i].char_code;
            it.last      = directed_table[i].last;
            send_item(it, directed_table[i].has_exp, directed_table[i].exp);
        end

        // over-long raw input: leading blanks saturate the offset, then a short address
        addr_units.delete();
        repeat (1030) addr_units.push_back(CH_SPACE);
        addr_units.push_back("a");
        addr_units.push_back(CH_AT);
        addr_units.push_back("b");
        addr_units.push_back(CH_DOT);
        addr_units.push_back("c");
        send_address();

        // sender pause until the block has handed back everything
        in_valid <= 1'b0;
        do @(posedge clk); while (pending_results.size() != 0);

        while (random_items < RANDOM_ITEMS) begin
            // one long receiver hold-off while items keep coming
            if (!hold_done && random_items >= RANDOM_ITEMS / 3) begin
                hold_req  = 1'b1;
                hold_done = 1'b1;
            end
            build_address();
            send_address();
            random_items += addr_units.size();
        end
        in_valid <= 1'b0;

        // drain, then keep the clock running to catch any stray result
        while (pending_results.size() != 0) @(posedge clk);
        repeat (10) @(posedge clk);
        if (fail_count == 0) begin
            $display("** email_address_stream_validator_top: PASSED **");
        end else begin
            $display("** email_address_stream_validator_top: FAILED **");
        end
        $finish;
    end

    // ---------------------------------------------------------------- receiver

    // stall pattern changes every span: always ready, coin flip, one in four, mostly ready
    initial begin : receiver
        int mode, span, cyc;
        forever begin
            mode = $urandom_range(3);
            span = $urandom_range(20, 200);
            for (cyc = 0; cyc < span; cyc++) begin
                @(posedge clk);
                if (hold_req) begin
                    out_ready <= 1'b0;
                    repeat (HOLD_OFF_CYCLES) @(posedge clk);
                    hold_req = 1'b0;
                end
                case (mode)
                    0:       out_ready <= 1'b1;
                    1:       out_ready <= 1'($urandom_range(1));
                    2:       out_ready <= (cyc % 4 == 3);
                    default: out_ready <= ($urandom_range(9) != 0);
                endcase
            end
        end
    end

    // ---------------------------------------------------------------- result check

    task automatic check_field(string name, int unsigned want, int unsigned got);
        if (want != got) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            fail_count++;
        end
    endtask

    always @(posedge clk) begin : result_check
        t_out_item want;
        if (rst_n && out_valid && out_ready) begin
            if (pending_results.size() == 0) begin
                $error("result item with no result expected: 0x%0h", out_item);
                fail_count++;
            end else begin
                want = pending_results.pop_front();
                check_field("lower_char",   want.lower_char,   out_item.lower_char);
                check_field("done_res",     want.done_res,     out_item.done_res);
                check_field("valid_res",    want.valid_res,    out_item.valid_res);
                check_field("start_offset", want.start_offset, out_item.start_offset);
                check_field("email_length", want.email_length, out_item.email_length);
            end
        end
    end

    // hard stop if the handshakes hang
    initial begin : run_limit
        #(RUN_LIMIT_NS);
        $display("** email_address_stream_validator_top: FAILED **");
        $finish;
    end

endmodule
